@@ hdl/tlbr_pkg.sv @@
// Package for the LRU TLB refill unit: request, response and queue types,
// operation codes, back-end states and register map constants.
// No dependencies.
package tlbr_pkg;

   // Fixed field widths of the request and response channels and the register port
   localparam int PAGE_W  = 10;
   localparam int TICK_W  = 32;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register index taken from the word address
   localparam logic CSR_PAGE_COUNT = 1'b0;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_REFILL    = 2'd0,
      KIND_SAVE      = 2'd1,
      KIND_INVAL_ALL = 2'd2,
      KIND_SHOOT     = 2'd3
   } kind_type;

   // Request as it arrives on the input port
   typedef struct packed {
      logic [1:0]        kind;
      logic [PAGE_W-1:0] virtual_page;
      logic [PAGE_W-1:0] physical_page;
      logic              read_only;
      logic              use_in;
      logic              dirty_in;
      logic [TICK_W-1:0] now_tick;
   } req_type;

   // One response item
   typedef struct packed {
      logic              writeback_valid;
      logic [PAGE_W-1:0] wb_page;
      logic              wb_use;
      logic              wb_dirty;
      logic [TICK_W-1:0] wb_last_used;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } rsp_type;

   // Classified request held in the queue between front and back end
   typedef struct packed {
      kind_type          op;
      logic [PAGE_W-1:0] vpage;
      logic [PAGE_W-1:0] ppage;
      logic              read_only;
      logic              use_bit;
      logic              dirty_bit;
      logic [TICK_W-1:0] tick;
   } cmd_type;

   // Head of the request queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_FILL,
      BK_FLUSH
   } back_state_type;

endpackage

@@ hdl/tlbr_front.sv @@
// Front end of the LRU TLB refill unit: accepts requests, classifies them
// and holds them in a two-entry queue for the back end.
// Depends on tlbr_pkg.
module tlbr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  tlbr_pkg::req_type        req_data,
   output logic                     busy,
   output tlbr_pkg::queue_head_type head,
   input  logic                     pop
);

   tlbr_pkg::cmd_type queue_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   tlbr_pkg::cmd_type cmd;
   logic              push;

   // Refuse requests while the queue is full
   assign busy = (count_ff == 2'd2);
   assign push = start & ~busy;

   // Classify the request into a queue entry
   always_comb begin
      cmd.op        = tlbr_pkg::kind_type'(req_data.kind);
      cmd.vpage     = req_data.virtual_page;
      cmd.ppage     = req_data.physical_page;
      cmd.read_only = req_data.read_only;
      cmd.use_bit   = req_data.use_in;
      cmd.dirty_bit = req_data.dirty_in;
      cmd.tick      = req_data.now_tick;
   end

   // Advance the queue pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   // Present the oldest entry
   always_comb begin
      head.valid = (count_ff != 2'd0);
      head.cmd   = queue_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed requests
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

@@ hdl/tlbr_back.sv @@
// Back end of the LRU TLB refill unit: holds the TLB slots and walks them
// one per cycle to refill, save or shoot down; invalidate-all clears them all.
// Depends on tlbr_pkg.
module tlbr_back #(
   parameter int TLB_SLOTS = 4,
   parameter int PAGE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tlbr_pkg::COUNT_W-1:0]        page_count,
   input  tlbr_pkg::queue_head_type            head,
   output logic                                pop,
   output logic                                rsp_strobe,
   output tlbr_pkg::rsp_type                   rsp_data
);

   localparam int IDX_W = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;
   localparam int CMP_W = (PAGE_BITS > tlbr_pkg::COUNT_W) ? PAGE_BITS : tlbr_pkg::COUNT_W;

   // Slot storage
   logic [TLB_SLOTS-1:0]          valid_ff, valid_in;
   logic [PAGE_BITS-1:0]          vpage_ff [TLB_SLOTS];
   logic [PAGE_BITS-1:0]          ppage_ff [TLB_SLOTS];
   logic                          ro_ff    [TLB_SLOTS];
   logic                          use_ff   [TLB_SLOTS];
   logic                          dirty_ff [TLB_SLOTS];
   logic [tlbr_pkg::TICK_W-1:0]   lu_ff    [TLB_SLOTS];
   logic                          fill_we;

   // Sequencer state
   tlbr_pkg::back_state_type      state_ff, state_in;
   tlbr_pkg::cmd_type             cmd_ff, cmd_in;
   logic [IDX_W-1:0]              ptr_ff, ptr_in;
   logic [IDX_W-1:0]              victim_ff, victim_in;
   logic                          found_ff, found_in;
   logic [tlbr_pkg::TICK_W-1:0]   min_ff, min_in;
   tlbr_pkg::rsp_type             held_ff, held_in;
   logic                          held_valid_ff, held_valid_in;
   tlbr_pkg::rsp_type             out_ff, out_in;
   logic                          strobe_ff, strobe_in;

   // Slot under the scan pointer
   logic [PAGE_BITS-1:0]          rd_vpage;
   logic [tlbr_pkg::TICK_W-1:0]   rd_lu;
   logic                          rd_valid;
   logic                          below_count;
   logic                          page_match;
   logic                          last_slot;
   tlbr_pkg::rsp_type             entry_rsp;
   logic                          hit;

   assign rd_vpage    = vpage_ff[ptr_ff];
   assign rd_lu       = lu_ff[ptr_ff];
   assign rd_valid    = valid_ff[ptr_ff];
   assign below_count = CMP_W'(rd_vpage) < CMP_W'(page_count);
   assign page_match  = (rd_vpage == PAGE_BITS'(cmd_ff.vpage));
   assign last_slot   = (ptr_ff == IDX_W'(TLB_SLOTS - 1));

   // Write-back item built from the slot under the pointer
   always_comb begin
      entry_rsp.writeback_valid = 1'b1;
      entry_rsp.wb_page         = tlbr_pkg::PAGE_W'(rd_vpage);
      entry_rsp.wb_use          = use_ff[ptr_ff];
      entry_rsp.wb_dirty        = dirty_ff[ptr_ff];
      entry_rsp.wb_last_used    = rd_lu;
      entry_rsp.slot            = tlbr_pkg::SLOT_W'(ptr_ff);
      entry_rsp.last            = 1'b0;
   end

   // Next state and outputs of the sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ptr_in        = ptr_ff;
      victim_in     = victim_ff;
      found_in      = found_ff;
      min_in        = min_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      out_in        = out_ff;
      strobe_in     = 1'b0;
      valid_in      = valid_ff;
      fill_we       = 1'b0;
      pop           = 1'b0;
      hit           = 1'b0;
      case (state_ff)
         tlbr_pkg::BK_IDLE: begin
            if (head.valid) begin
               pop           = 1'b1;
               cmd_in        = head.cmd;
               ptr_in        = '0;
               found_in      = 1'b0;
               held_valid_in = 1'b0;
               if (head.cmd.op == tlbr_pkg::KIND_INVAL_ALL) begin
                  valid_in = '0;
               end else begin
                  state_in = tlbr_pkg::BK_SCAN;
               end
            end
         end
         tlbr_pkg::BK_SCAN: begin
            case (cmd_ff.op)
               tlbr_pkg::KIND_REFILL: begin
                  // Track the first free slot, else the oldest one
                  if (!found_ff) begin
                     if (!rd_valid) begin
                        found_in  = 1'b1;
                        victim_in = ptr_ff;
                     end else if ((ptr_ff == '0) || (rd_lu < min_ff)) begin
                        min_in    = rd_lu;
                        victim_in = ptr_ff;
                     end
                  end
                  if (last_slot) begin
                     ptr_in   = victim_in;
                     state_in = tlbr_pkg::BK_FILL;
                  end else begin
                     ptr_in = ptr_ff + IDX_W'(1);
                  end
               end
               default: begin
                  // Save drops every valid slot, shoot-down only matching ones
                  if (rd_valid) begin
                     if (cmd_ff.op == tlbr_pkg::KIND_SAVE) begin
                        valid_in[ptr_ff] = 1'b0;
                        hit              = below_count;
                     end else if (page_match) begin
                        valid_in[ptr_ff] = 1'b0;
                        hit              = 1'b1;
                     end
                  end
                  // Release the previous hit, hold this one until the next
                  if (hit) begin
                     if (held_valid_ff) begin
                        strobe_in = 1'b1;
                        out_in    = held_ff;
                     end
                     held_in       = entry_rsp;
                     held_valid_in = 1'b1;
                  end
                  if (last_slot) begin
                     state_in = tlbr_pkg::BK_FLUSH;
                  end else begin
                     ptr_in = ptr_ff + IDX_W'(1);
                  end
               end
            endcase
         end
         tlbr_pkg::BK_FILL: begin
            // Report the victim and load the new entry
            held_in = entry_rsp;
            if (!(rd_valid && below_count)) begin
               held_in.writeback_valid = 1'b0;
               held_in.wb_page         = '0;
               held_in.wb_use          = 1'b0;
               held_in.wb_dirty        = 1'b0;
               held_in.wb_last_used    = '0;
            end
            held_valid_in    = 1'b1;
            fill_we          = 1'b1;
            valid_in[ptr_ff] = 1'b1;
            state_in         = tlbr_pkg::BK_FLUSH;
         end
         tlbr_pkg::BK_FLUSH: begin
            // Send the held item as the final one
            if (held_valid_ff) begin
               strobe_in   = 1'b1;
               out_in      = held_ff;
               out_in.last = 1'b1;
            end
            held_valid_in = 1'b0;
            state_in      = tlbr_pkg::BK_IDLE;
         end
         default: begin
            state_in = tlbr_pkg::BK_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tlbr_pkg::BK_IDLE;
         valid_ff      <= '0;
         held_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         held_valid_ff <= held_valid_in;
         strobe_ff     <= strobe_in;
         found_ff      <= found_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      ptr_ff    <= ptr_in;
      victim_ff <= victim_in;
      min_ff    <= min_in;
      held_ff   <= held_in;
      out_ff    <= out_in;
   end

   // Load a slot on refill
   always_ff @(posedge clock) begin
      if (fill_we) begin
         vpage_ff[ptr_ff] <= PAGE_BITS'(cmd_ff.vpage);
         ppage_ff[ptr_ff] <= PAGE_BITS'(cmd_ff.ppage);
         ro_ff[ptr_ff]    <= cmd_ff.read_only;
         use_ff[ptr_ff]   <= cmd_ff.use_bit;
         dirty_ff[ptr_ff] <= cmd_ff.dirty_bit;
         lu_ff[ptr_ff]    <= cmd_ff.tick;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = out_ff;

endmodule

@@ hdl/tlb_lru_refill_unit.sv @@
// LRU TLB refill unit: top level with the register port.
// Depends on tlbr_pkg, tlbr_front and tlbr_back.
//
// Usage:
//   A request is taken on a rising edge with start high and busy low. Its
//   kind selects refill (load an entry into the first free slot, else the
//   least recently used one), save-and-invalidate, invalidate-all, or
//   shoot-down of one page. Requests wait in a two-entry queue; busy is
//   high only while that queue is full.
//   Each response is shown for one cycle with rsp_strobe high; the last
//   response of a request has last set. The receiver cannot stall.
//   Refill gives one response; save and shoot-down give one per written-back
//   slot, in slot order; invalidate-all gives none.
//   Timing: the back end walks one slot per cycle. A refill then passes
//   through a fill step and a flush step, save and shoot-down through a
//   flush step; invalidate-all clears the slots without a walk. The final
//   response is sent from the flush step through an output register.
//   Register page_count sits at byte address 0 and is to be written only
//   while the unit is idle; the block itself does not enforce this. Reset
//   clears page_count, the queue and every slot's valid bit.
module tlb_lru_refill_unit #(
   parameter int TLB_SLOTS = 4,
   parameter int PAGE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  tlbr_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output tlbr_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tlbr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tlbr_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tlbr_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic [tlbr_pkg::COUNT_W-1:0] page_count_ff, page_count_in;
   logic                         csr_write;
   tlbr_pkg::queue_head_type     head;
   logic                         pop;

   // Decode register writes
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      page_count_in = page_count_ff;
      if (csr_write && (paddr[2] == tlbr_pkg::CSR_PAGE_COUNT)) begin
         page_count_in = pwdata[tlbr_pkg::COUNT_W-1:0];
      end
   end

   // Return the addressed register
   always_comb begin
      if (paddr[2] == tlbr_pkg::CSR_PAGE_COUNT) begin
         prdata = tlbr_pkg::CSR_DATA_W'(page_count_ff);
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= '0;
      end else begin
         page_count_ff <= page_count_in;
      end
   end

   tlbr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .head     (head),
      .pop      (pop)
   );

   tlbr_back #(
      .TLB_SLOTS (TLB_SLOTS),
      .PAGE_BITS (PAGE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .page_count (page_count_ff),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ tb/sv/tlb_lru_refill_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for tlb_lru_refill_unit. It drives refill, save, invalidate-all
// and shoot-down requests, and checks every response against a shadow TLB.
// Depends on tlbr_pkg and the RTL of the unit.
module tlb_lru_refill_unit_tb;

   localparam int SLOTS = 4;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 50;
   localparam logic [tlbr_pkg::CSR_ADDR_W-1:0] PAGE_COUNT_ADDR =
      {tlbr_pkg::CSR_PAGE_COUNT, 2'b00};
   // page_count and sender idle percentage of each random phase; -1 picks a random count
   localparam int PHASE_PAGES [6] = '{1024, 0, 512, -1, 1, 1023};
   localparam int PHASE_IDLE [6] = '{0, 49, 0, 26, 49, 0};

   // Shadow copy of the TLB and the write-backs it predicts
   class tlb_shadow;
      bit                           slot_valid [SLOTS];
      logic [tlbr_pkg::PAGE_W-1:0]  slot_vpage [SLOTS];
      logic [tlbr_pkg::PAGE_W-1:0]  slot_ppage [SLOTS];
      logic                         slot_ro [SLOTS];
      logic                         slot_use [SLOTS];
      logic                         slot_dirty [SLOTS];
      logic [tlbr_pkg::TICK_W-1:0]  slot_stamp [SLOTS];
      logic [tlbr_pkg::COUNT_W-1:0] page_count = '0;
      tlbr_pkg::rsp_type            writebacks[$];
      int                           mismatches = 0;

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function tlbr_pkg::rsp_type writeback(int s);
         tlbr_pkg::rsp_type r;
         r = '0;
         r.writeback_valid = 1'b1;
         r.wb_page = slot_vpage[s];
         r.wb_use = slot_use[s];
         r.wb_dirty = slot_dirty[s];
         r.wb_last_used = slot_stamp[s];
         r.slot = tlbr_pkg::SLOT_W'(s);
         return r;
      endfunction

      // Apply one accepted request and queue the responses it causes
      function void note(tlbr_pkg::req_type r);
         tlbr_pkg::rsp_type  burst[$];
         tlbr_pkg::rsp_type  e;
         tlbr_pkg::kind_type k;
         int                 victim;
         bit                 hit;
         k = tlbr_pkg::kind_type'(r.kind);
         victim = -1;
         case (k)
         tlbr_pkg::KIND_REFILL: begin
            // first free slot, else the oldest stamp (lowest slot on a tie)
            for (int i = 0; i < SLOTS; i++)
               if (!slot_valid[i] && victim < 0) victim = i;
            if (victim < 0) begin
               victim = 0;
               for (int i = 1; i < SLOTS; i++)
                  if (slot_stamp[i] < slot_stamp[victim]) victim = i;
            end
            e = '0;
            if (slot_valid[victim] && {1'b0, slot_vpage[victim]} < page_count)
               e = writeback(victim);
            e.slot = tlbr_pkg::SLOT_W'(victim);
            burst.push_back(e);
            slot_valid[victim] = 1'b1;
            slot_vpage[victim] = r.virtual_page;
            slot_ppage[victim] = r.physical_page;
            slot_ro[victim] = r.read_only;
            slot_use[victim] = r.use_in;
            slot_dirty[victim] = r.dirty_in;
            slot_stamp[victim] = r.now_tick;
         end
         tlbr_pkg::KIND_INVAL_ALL: begin
            for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
         end
         default: begin
            // save drops every valid slot; shoot-down only the matching ones
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_valid[i]) begin
                  if (k == tlbr_pkg::KIND_SAVE) hit = {1'b0, slot_vpage[i]} < page_count;
                  else hit = slot_vpage[i] == r.virtual_page;
                  if (k == tlbr_pkg::KIND_SAVE || hit) slot_valid[i] = 1'b0;
                  if (hit) burst.push_back(writeback(i));
               end
            end
         end
         endcase
         if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
         foreach (burst[i]) writebacks.push_back(burst[i]);
      endfunction

      task compare(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
      endtask

      // Compare one response with the oldest expectation
      task check(tlbr_pkg::rsp_type got);
         tlbr_pkg::rsp_type want;
         if (writebacks.size() == 0) begin
            report($sformatf("response for slot %0d with none expected", got.slot));
            return;
         end
         want = writebacks.pop_front();
         compare("writeback_valid", 32'(got.writeback_valid), 32'(want.writeback_valid));
         compare("wb_page", 32'(got.wb_page), 32'(want.wb_page));
         compare("wb_use", 32'(got.wb_use), 32'(want.wb_use));
         compare("wb_dirty", 32'(got.wb_dirty), 32'(want.wb_dirty));
         compare("wb_last_used", got.wb_last_used, want.wb_last_used);
         compare("slot", 32'(got.slot), 32'(want.slot));
         compare("last", 32'(got.last), 32'(want.last));
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   tlbr_pkg::req_type               req_data;
   logic                            rsp_strobe;
   tlbr_pkg::rsp_type               rsp_data;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [tlbr_pkg::CSR_ADDR_W-1:0] paddr;
   logic [tlbr_pkg::CSR_DATA_W-1:0] pwdata;
   logic [tlbr_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   tlb_shadow   shadow = new;
   int          cycle_count = 0;
   logic [31:0] tick_now = 32'd1000;

   tlb_lru_refill_unit #(
      .TLB_SLOTS (SLOTS),
      .PAGE_BITS (tlbr_pkg::PAGE_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check responses, then note requests taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) shadow.check(rsp_data);
         if (start && !busy) shadow.note(req_data);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tlb_lru_refill_unit_tb: FAIL");
         $finish;
      end
   end

   function tlbr_pkg::req_type make_req(tlbr_pkg::kind_type k, int vp, int pp, int ro,
                                        int u, int d, logic [31:0] tick);
      tlbr_pkg::req_type r;
      r.kind = k;
      r.virtual_page = tlbr_pkg::PAGE_W'(vp);
      r.physical_page = tlbr_pkg::PAGE_W'(pp);
      r.read_only = ro[0];
      r.use_in = u[0];
      r.dirty_in = d[0];
      r.now_tick = tick;
      return r;
   endfunction

   // Mostly rising ticks with repeats, sometimes extremes or anything at all
   function logic [31:0] next_tick();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      if (pick < 15) return $urandom;
      tick_now = tick_now + $urandom_range(3);
      return tick_now;
   endfunction

   // Random request whose pages mostly fall in a pool around page_count
   function tlbr_pkg::req_type random_req(int pool_base);
      int                 pick;
      int                 vp;
      tlbr_pkg::kind_type k;
      pick = $urandom_range(99);
      if (pick < 55) k = tlbr_pkg::KIND_REFILL;
      else if (pick < 80) k = tlbr_pkg::KIND_SHOOT;
      else if (pick < 90) k = tlbr_pkg::KIND_SAVE;
      else k = tlbr_pkg::KIND_INVAL_ALL;
      if ($urandom_range(99) < 80) vp = (pool_base + $urandom_range(7)) & 10'h3FF;
      else vp = $urandom_range(1023);
      return make_req(k, vp, $urandom_range(1023), $urandom_range(1), $urandom_range(1),
                      $urandom_range(1), next_tick());
   endfunction

   // Offer one request after a random gap and hold it until taken
   task send_req(tlbr_pkg::req_type r, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until the unit has gone quiet
   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (shadow.writebacks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write page_count, then read it back
   task set_page_count(logic [tlbr_pkg::COUNT_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PAGE_COUNT_ADDR;
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      shadow.page_count = value;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(value))
         shadow.report($sformatf("page_count read 0x%0h, wrote 0x%0h", prdata, value));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int pages;
      int pool_base;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill, LRU eviction with ties, page_count boundary, flushes
      set_page_count(11'd8);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 3, 1, 0, 1, 0, 32'd100), 0);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 9, 2, 1, 0, 1, 32'd0), 0);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 10'h3FF, 10'h3FF, 1, 1, 1, 32'hFFFF_FFFF), 0);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 3, 0, 0, 0, 0, 32'd100), 0);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 5, 5, 0, 1, 1, 32'd50), 0);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 6, 6, 1, 0, 0, 32'd200), 0);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 7, 7, 0, 1, 0, 32'd300), 0);
      send_req(make_req(tlbr_pkg::KIND_SHOOT, 3, 0, 0, 0, 0, 32'd0), 0);
      send_req(make_req(tlbr_pkg::KIND_SHOOT, 10'h155, 0, 0, 0, 0, 32'd0), 0);
      send_req(make_req(tlbr_pkg::KIND_SAVE, 0, 0, 0, 0, 0, 32'd0), 0);
      send_req(make_req(tlbr_pkg::KIND_SAVE, 0, 0, 0, 0, 0, 32'd0), 0);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 2, 10'h2AA, 1, 1, 1, 32'd1), 0);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 2, 10'h155, 0, 0, 0, 32'd1), 0);
      send_req(make_req(tlbr_pkg::KIND_SHOOT, 2, 0, 0, 0, 0, 32'd0), 0);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 1, 1, 0, 0, 1, 32'd7), 0);
      send_req(make_req(tlbr_pkg::KIND_INVAL_ALL, 0, 0, 0, 0, 0, 32'd0), 0);
      send_req(make_req(tlbr_pkg::KIND_REFILL, 4, 4, 0, 1, 1, 32'd9), 0);
      send_req(make_req(tlbr_pkg::KIND_SHOOT, 4, 0, 0, 0, 0, 32'd0), 0);
      drain();

      // Random phases, each with its own page_count and sender idling
      for (int ph = 0; ph < 6; ph++) begin
         pages = (PHASE_PAGES[ph] < 0) ? $urandom_range(1024) : PHASE_PAGES[ph];
         set_page_count(tlbr_pkg::COUNT_W'(pages));
         pool_base = (pages >= 4) ? pages - 4 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_req(random_req(pool_base), PHASE_IDLE[ph]);
         drain();
      end

      if (shadow.mismatches == 0) begin
         $display("tlb_lru_refill_unit_tb: PASS");
      end else begin
         $display("tlb_lru_refill_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/tlbr_pkg.sv
hdl/tlbr_front.sv
hdl/tlbr_back.sv
hdl/tlb_lru_refill_unit.sv
tb/sv/tlb_lru_refill_unit_tb.sv
